### rtl/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising edge, off while reset is held.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// Condition that must never be true out of reset.
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  `ASSERT_CLKD(lbl, clk, rstn, !(cond))

`endif

### rtl/fds_pkg.sv
`default_nettype none
package fds_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int RING_DEPTH   = 32768;
  localparam int RING_AW      = $clog2(RING_DEPTH);
  localparam int FILL_W       = RING_AW + 1;

  localparam int DLY_W    = 14;
  localparam int STEP_W   = 4;
  localparam int BLEN_W   = 9;
  localparam int BPOS_W   = 8;
  localparam int FLAT_W   = SAMPLE_WIDTH + 12;
  localparam int LIM_W    = SAMPLE_WIDTH + 7;
  localparam int CMP_W    = DLY_W + SAMPLE_WIDTH - 1;
  localparam int BACK_W   = DLY_W + 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [DLY_W-1:0]        dly_t;
  typedef logic signed [STEP_W-1:0]       step_t;

  localparam dly_t  DLY_RESET   = 14'sd5;
  localparam dly_t  DLY_MIN     = 14'sd5;
  localparam dly_t  DLY_OFFSET  = 14'sd50;
  localparam logic [11:0] FLAT_SCALE = 12'd2475;
  localparam logic [6:0]  LIM_SCALE  = 7'd50;
  localparam logic [LIM_W-1:0] LIM_BIAS =
    LIM_W'(50 * (1 << (SAMPLE_WIDTH - 1)));

  localparam step_t STEP_ONE  = 4'sd1;
  localparam step_t STEP_TWO  = 4'sd2;
  localparam step_t STEP_FIVE = 4'sd5;
  localparam step_t STEP_FLAT = 4'sd0;

  localparam logic [BLEN_W-1:0] BLEN_RESET = 9'd100;
  localparam logic [BLEN_W-1:0] BLEN_MAX   = 9'd256;
  localparam logic [BLEN_W-1:0] BLEN_MIN   = 9'd1;

  // Sample waiting on its ring read.
  typedef struct packed {
    sample_t audio;
    sample_t pot;
    logic    fwd;    // zero delay: use the sample just written
    logic    blank;  // entry not written since reset: reads as zero
  } rd_stage_t;

endpackage
`default_nettype wire

### rtl/flanger_delay_sweep.sv
`default_nettype none
// Channel | Dir | Handshake             | Payload
// in      | in  | in_valid / in_ready   | in_kind, in_audio_in, in_pot_in
// out     | out | out_valid / out_ready | out_mixed_out, out_pot_echo
// cfg     | in  | cfg_wr_en, no wait    | cfg_wr_data (block_len)
// One item per cycle sustained while in_ready stays high; a sample's result
// passes through the ring read register and then the output register.
// Button items produce no result.
// Delay, step and block state update in the transfer cycle, so the next item
// sees them at once. Reset is synchronous; the ring needs no clearing pass,
// a fill count masks entries not yet written.
// in_ready drops only when the read stage and the output register are both
// full and out_ready is low.
module flanger_delay_sweep import fds_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic                    in_kind,
  input  wire sample_t                 in_audio_in,
  input  wire sample_t                 in_pot_in,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output sample_t                      out_mixed_out,
  output sample_t                      out_pot_echo,
  input  wire logic                    cfg_wr_en,
  input  wire logic [BLEN_W-1:0]       cfg_wr_data
);

`include "assert_macros.svh"

  logic [BLEN_W-1:0]        block_len_r;
  logic [RING_AW-1:0]       write_pos_r, write_pos_nxt;
  logic [FILL_W-1:0]        fill_r, fill_nxt;
  dly_t                     delay_r, delay_nxt;
  step_t                    step_r, step_nxt;
  logic [BPOS_W-1:0]        block_pos_r, block_pos_nxt;
  sample_t                  block_pot_r, block_pot_nxt;

  logic                     s1_valid_r, s1_valid_nxt;
  rd_stage_t                s1_r;
  sample_t                  rd_data_r;
  logic                     out_valid_r;
  sample_t                  out_mixed_r, out_pot_r;

  sample_t                  ring_mem [RING_DEPTH];

  logic                     acc, acc_smp, acc_btn, out_ld;
  sample_t                  pot_cur;
  logic [SAMPLE_WIDTH-1:0]  pot_u;
  logic [FLAT_W-1:0]        flat_prod;
  dly_t                     flat_dly, sweep_dly;
  logic [LIM_W-1:0]         lim_rhs;
  logic signed [CMP_W-1:0]  lim_lhs_s, lim_rhs_s;
  logic                     flip_hi, flip_lo;
  logic [DLY_W-2:0]         dly_pos;
  logic [BACK_W-1:0]        back_full;
  logic [RING_AW-1:0]       back, rd_addr;
  logic [BLEN_W-1:0]        len_eff, pos_inc;
  logic                     blk_end;
  sample_t                  d_sel;
  logic signed [SAMPLE_WIDTH:0] mix_sum;

  assign out_ld   = !out_valid_r || out_ready;
  assign in_ready = !s1_valid_r || out_ld;
  assign acc      = in_valid && in_ready;
  assign acc_smp  = acc && !in_kind;
  assign acc_btn  = acc && in_kind;

  // Pot of the block's first pair, including the pair being taken now.
  assign pot_cur = (block_pos_r == '0) ? in_pot_in : block_pot_r;
  assign pot_u   = {~pot_cur[SAMPLE_WIDTH-1], pot_cur[SAMPLE_WIDTH-2:0]};

  // Flat mode: floor(2475*(p+S)/S) + 50
  assign flat_prod = pot_u * FLAT_SCALE;
  assign flat_dly  = DLY_W'(flat_prod >> (SAMPLE_WIDTH - 1)) + DLY_OFFSET;

  // Sweep mode: step, then reverse above the pot limit or below the floor
  assign sweep_dly = delay_r + DLY_W'(step_r);
  assign lim_rhs   = LIM_W'(pot_u) * LIM_SCALE + LIM_BIAS;
  assign lim_lhs_s = $signed({sweep_dly, {(SAMPLE_WIDTH-1){1'b0}}});
  assign lim_rhs_s = $signed({{(CMP_W-LIM_W){1'b0}}, lim_rhs});
  assign flip_hi   = lim_lhs_s > lim_rhs_s;
  assign flip_lo   = sweep_dly < DLY_MIN;

  // Ring read offset: delay*5 positions back, negative delay clamps to zero
  assign dly_pos   = delay_r[DLY_W-1] ? '0 : delay_r[DLY_W-2:0];
  assign back_full = {dly_pos, 2'b00} + BACK_W'(dly_pos);
  assign back      = back_full[RING_AW-1:0];
  assign rd_addr   = write_pos_r - back;

  always_comb begin
    len_eff = block_len_r;
    if (block_len_r == '0) begin
      len_eff = BLEN_MIN;
    end else if (block_len_r > BLEN_MAX) begin
      len_eff = BLEN_MAX;
    end
  end

  assign pos_inc = {1'b0, block_pos_r} + BLEN_W'(1);
  assign blk_end = pos_inc >= len_eff;

  always_comb begin
    write_pos_nxt = write_pos_r;
    fill_nxt      = fill_r;
    delay_nxt     = delay_r;
    step_nxt      = step_r;
    block_pos_nxt = block_pos_r;
    block_pot_nxt = block_pot_r;
    if (acc_smp) begin
      write_pos_nxt = write_pos_r + RING_AW'(1);
      if (fill_r != FILL_W'(RING_DEPTH)) begin
        fill_nxt = fill_r + FILL_W'(1);
      end
      block_pot_nxt = pot_cur;
      if (blk_end) begin
        block_pos_nxt = '0;
        if (step_r != STEP_FLAT) begin
          delay_nxt = sweep_dly;
          if (flip_hi ^ flip_lo) begin
            step_nxt = -step_r;
          end
        end else begin
          delay_nxt = flat_dly;
        end
      end else begin
        block_pos_nxt = pos_inc[BPOS_W-1:0];
      end
    end else if (acc_btn) begin
      // negative steps leave the button without effect
      unique case (step_r)
        STEP_ONE:  step_nxt = STEP_TWO;
        STEP_TWO:  step_nxt = STEP_FIVE;
        STEP_FIVE: step_nxt = STEP_FLAT;
        STEP_FLAT: begin
          step_nxt  = STEP_ONE;
          delay_nxt = DLY_RESET;
        end
        default:   step_nxt = step_r;
      endcase
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (acc_smp) begin
      s1_valid_nxt = 1'b1;
    end else if (out_ld) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_len_r <= BLEN_RESET;
      write_pos_r <= '0;
      fill_r      <= '0;
      delay_r     <= DLY_RESET;
      step_r      <= STEP_ONE;
      block_pos_r <= '0;
      block_pot_r <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        block_len_r <= cfg_wr_data;
      end
      write_pos_r <= write_pos_nxt;
      fill_r      <= fill_nxt;
      delay_r     <= delay_nxt;
      step_r      <= step_nxt;
      block_pos_r <= block_pos_nxt;
      block_pot_r <= block_pot_nxt;
      s1_valid_r  <= s1_valid_nxt;
      if (out_ld) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  // Ring: write the new sample, read the delayed one; read data held on stall
  always_ff @(posedge clk) begin
    if (acc_smp) begin
      ring_mem[write_pos_r] <= in_audio_in;
      rd_data_r             <= ring_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (acc_smp) begin
      s1_r.audio <= in_audio_in;
      s1_r.pot   <= pot_cur;
      s1_r.fwd   <= back == '0;
      s1_r.blank <= FILL_W'(back) > fill_r;
    end
  end

  always_comb begin
    d_sel = rd_data_r;
    if (s1_r.fwd) begin
      d_sel = s1_r.audio;
    end else if (s1_r.blank) begin
      d_sel = '0;
    end
  end

  assign mix_sum = (SAMPLE_WIDTH+1)'(s1_r.audio) + (SAMPLE_WIDTH+1)'(d_sel);

  always_ff @(posedge clk) begin
    if (out_ld && s1_valid_r) begin
      out_mixed_r <= mix_sum[SAMPLE_WIDTH:1];
      out_pot_r   <= s1_r.pot;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_mixed_out = out_mixed_r;
  assign out_pot_echo  = out_pot_r;

  `ASSERT_NEVER(a_fill_bound, clk, rst_n, fill_r > FILL_W'(RING_DEPTH))
  `ASSERT_CLKD(a_step_legal, clk, rst_n,
    step_r == STEP_ONE || step_r == STEP_TWO || step_r == STEP_FIVE ||
    step_r == STEP_FLAT || step_r == -STEP_ONE || step_r == -STEP_TWO ||
    step_r == -STEP_FIVE)
  `ASSERT_CLKD(a_s1_hold, clk, rst_n, (s1_valid_r && !out_ld) |=> s1_valid_r)
  `ASSERT_CLKD(a_btn_no_result, clk, rst_n,
    (acc_btn && !s1_valid_r) |=> !s1_valid_r)
  `ASSERT_CLKD(a_wpos_step, clk, rst_n,
    acc_smp |=> write_pos_r == RING_AW'($past(write_pos_r) + RING_AW'(1)))

endmodule
`default_nettype wire

### tb/fds_tb_pkg.sv
package fds_tb_pkg;
  import fds_pkg::*;

  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_BUTTON = 1'b1
  } item_kind_t;

  // One flanger result: mixed sample and the pot value of the current block.
  typedef struct packed {
    sample_t mixed;
    sample_t pot;
  } flange_result_t;

endpackage

### tb/flanger_delay_checker.sv
module flanger_delay_checker
  import fds_pkg::*;
  import fds_tb_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic                    in_ready,
  input  logic                    in_kind,
  input  logic signed [15:0]      in_audio_in,
  input  logic signed [15:0]      in_pot_in,
  input  logic                    out_valid,
  input  logic                    out_ready,
  input  logic signed [15:0]      out_mixed_out,
  input  logic signed [15:0]      out_pot_echo,
  input  logic                    cfg_wr_en,
  input  logic [BLEN_W-1:0]       cfg_wr_data,
  output int                      errors,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint HALF        = longint'(1) << (SAMPLE_WIDTH - 1);
  localparam longint FLAT_GAIN   = 2475;
  localparam longint SWEEP_GAIN  = 50;
  localparam int     TAPS_PER_TENTH = 5;
  localparam int     BLOCK_MAX   = 256;

  sample_t            ring_copy [RING_DEPTH];
  logic [RING_AW-1:0] wr_ptr;
  dly_t               delay_tenths_q;
  step_t              step_q;
  logic [8:0]         blk_pos;
  sample_t            blk_pot;
  logic [BLEN_W-1:0]  blk_len;
  flange_result_t     expected_mix_q [$];

  // Delay update once per block: sweep between the floor and the pot limit,
  // or in flat mode jump straight to the pot-scaled delay.
  function automatic void apply_block_end();
    longint pot_l;
    pot_l = blk_pot;
    if (step_q != STEP_FLAT) begin
      delay_tenths_q = delay_tenths_q + step_q;
      if (longint'(delay_tenths_q) * HALF >
          SWEEP_GAIN * (pot_l + HALF) + SWEEP_GAIN * HALF)
        step_q = -step_q;
      if (delay_tenths_q < DLY_MIN)
        step_q = -step_q;
    end else begin
      delay_tenths_q = dly_t'((FLAT_GAIN * (pot_l + HALF)) / HALF + DLY_OFFSET);
    end
  endfunction

  // Negative steps fall through the case untouched.
  function automatic void press_button();
    case (step_q)
      STEP_ONE:  step_q = STEP_TWO;
      STEP_TWO:  step_q = STEP_FIVE;
      STEP_FIVE: step_q = STEP_FLAT;
      STEP_FLAT: begin
        step_q = STEP_ONE;
        delay_tenths_q = DLY_RESET;
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_mix(input sample_t audio, input sample_t pot);
    int                         back;
    int                         len;
    logic [RING_AW-1:0]         rd_ptr;
    logic signed [SAMPLE_WIDTH:0] sum;
    flange_result_t             res;
    if (blk_pos == 0)
      blk_pot = pot;
    // write first: a zero delay reads back the sample just stored
    ring_copy[wr_ptr] = audio;
    back = (delay_tenths_q < 0) ? 0 : (int'(delay_tenths_q) * TAPS_PER_TENTH) % RING_DEPTH;
    rd_ptr = wr_ptr - back[RING_AW-1:0];
    sum = audio + ring_copy[rd_ptr];
    res.mixed = sample_t'(sum >>> 1);
    res.pot = blk_pot;
    expected_mix_q.push_back(res);
    wr_ptr = wr_ptr + 1'b1;
    len = (blk_len == 0) ? 1 : (blk_len > BLOCK_MAX) ? BLOCK_MAX : int'(blk_len);
    blk_pos = blk_pos + 1'b1;
    if (blk_pos >= len) begin
      blk_pos = '0;
      apply_block_end();
    end
  endfunction

  always @(posedge clk) begin
    flange_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < RING_DEPTH; i++)
        ring_copy[i] = '0;
      wr_ptr = '0;
      delay_tenths_q = DLY_RESET;
      step_q = STEP_ONE;
      blk_pos = '0;
      blk_pot = '0;
      blk_len = BLEN_RESET;
      expected_mix_q.delete();
      errors = 0;
    end else begin
      if (cfg_wr_en)
        blk_len = cfg_wr_data;
      if (out_valid && out_ready) begin
        if (expected_mix_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing expected, mixed_out %0d pot_echo %0d",
                   $time, out_mixed_out, out_pot_echo);
        end else begin
          want = expected_mix_q.pop_front();
          if (out_mixed_out !== want.mixed) begin
            errors++;
            $display("%0t: mixed_out expected %0d, actual %0d",
                     $time, want.mixed, out_mixed_out);
          end
          if (out_pot_echo !== want.pot) begin
            errors++;
            $display("%0t: pot_echo expected %0d, actual %0d",
                     $time, want.pot, out_pot_echo);
          end
        end
      end
      if (in_valid && in_ready) begin
        if (in_kind == KIND_BUTTON)
          press_button();
        else
          predict_mix(in_audio_in, in_pot_in);
      end
    end
    pending = expected_mix_q.size();
  end

endmodule

### tb/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import fds_pkg::*;
  import fds_tb_pkg::*;

  localparam sample_t SAMPLE_MAX   = 16'sh7fff;
  localparam sample_t SAMPLE_MIN   = -16'sh8000;
  localparam int      HOLD_CYCLES  = 80;
  localparam int      PHASES       = 10;
  localparam int      PHASE_ITEMS  = 165;
  localparam int      BUTTON_PCT   = 5;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              in_kind = KIND_SAMPLE;
  logic signed [15:0] in_audio_in = '0;
  logic signed [15:0] in_pot_in = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic signed [15:0] out_mixed_out;
  logic signed [15:0] out_pot_echo;
  logic              cfg_wr_en = 1'b0;
  logic [BLEN_W-1:0] cfg_wr_data = '0;

  int fail_count;
  int results_owed;
  int snd_idle = 15;
  int rcv_idle = 59;
  int hold_requests = 0;
  int holds_done = 0;
  int hold_left = 0;
  int phase_len [PHASES] = '{0, 256, 3, 511, 1, 300, 100, 17, 256, 2};

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  flanger_delay_sweep u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_audio_in   (in_audio_in),
    .in_pot_in     (in_pot_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mixed_out (out_mixed_out),
    .out_pot_echo  (out_pot_echo),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data)
  );

  flanger_delay_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_kind       (in_kind),
    .in_audio_in   (in_audio_in),
    .in_pot_in     (in_pot_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_mixed_out (out_mixed_out),
    .out_pot_echo  (out_pot_echo),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .errors        (fail_count),
    .pending       (results_owed)
  );

  // Result side: random stalls, plus a long hold when the stimulus asks.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (holds_done != hold_requests) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  function automatic sample_t rand_sample();
    case ($urandom_range(15))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      default: return sample_t'($urandom);
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_item(input item_kind_t kind, input sample_t audio, input sample_t pot);
    while ($urandom_range(99) < snd_idle) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_audio_in <= audio;
    in_pot_in <= pot;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic cfg_write(input logic [BLEN_W-1:0] value);
    cfg_wr_data <= value;
    cfg_wr_en <= 1'b1;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Drain all owed results, then wait out a trailing button transfer.
  task automatic settle();
    in_valid <= 1'b0;
    while (results_owed != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic send_sample(input sample_t audio, input sample_t pot);
    send_item(KIND_SAMPLE, audio, pot);
  endtask

  task automatic press();
    send_item(KIND_BUTTON, rand_sample(), rand_sample());
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: one-pair blocks so every pair moves the delay.
    cfg_write(BLEN_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    // step 1 -> 2 -> 5 -> flat
    press();
    press();
    press();
    // flat: lowest then highest delay; the third pair reads far back and wraps
    send_sample(rand_sample(), SAMPLE_MIN);
    send_sample(rand_sample(), SAMPLE_MAX);
    send_sample(rand_sample(), rand_sample());
    // leave flat mode, then up to step 5
    press();
    press();
    press();
    // lowest pot limit: the sweep overshoots and the step turns negative
    repeat (10) send_sample(rand_sample(), SAMPLE_MIN);
    // button is a no-op on a negative step
    press();
    settle();

    for (int ph = 0; ph < PHASES; ph++) begin
      if (ph == 4) begin
        snd_idle = 59;
        rcv_idle <= 15;
      end else if (ph == 7) begin
        snd_idle = 0;
        rcv_idle <= 0;
      end
      cfg_write(BLEN_W'(phase_len[ph]));
      if (ph == 8)
        hold_requests <= hold_requests + 1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < BUTTON_PCT)
          press();
        else
          send_sample(rand_sample(), rand_sample());
      end
      settle();
    end

    repeat (6) @(negedge clk);
    if (fail_count == 0 && results_owed == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
